// ===== hw/rtl/gas_sensor_response_model_macros.svh =====
// ----------------------------------------------------------------------------
// Gas sensor response model: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_RESPONSE_MODEL_MACROS_SVH
`define GAS_SENSOR_RESPONSE_MODEL_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GSRM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gas sensor model check failed");

// antecedent implies consequent in the next cycle
`define GSRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gas sensor model check failed");

`endif

// ===== hw/rtl/gsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// gsrm_pkg
// Types, constants and coefficient tables of the gas sensor response model.
// ----------------------------------------------------------------------------
package gsrm_pkg;

   localparam int SENSOR_SLOTS = 4;
   localparam int SLOT_W       = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

   localparam int CONC_W   = 22;
   localparam int KIND_W   = 2;
   localparam int SLOTIN_W = 2;
   localparam int TYPE_W   = 2;
   localparam int RATIO_W  = 21;
   localparam int ALPHA_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int EXP_STEPS = 20;
   localparam int K_W       = 5;

   localparam logic [RATIO_W-1:0] RATIO_MAX      = 21'h1F_FFFF;
   localparam logic [RATIO_W-1:0] HYDROGEN_FIXED = 21'd6554;

   localparam logic [KIND_W-1:0] GAS_HYDROGEN = 2'd2;
   localparam logic [TYPE_W-1:0] MODEL_ONE    = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA_RISE = 1'b0,
      CSR_ALPHA_FALL = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAG, ST_ULD, ST_EXP, ST_AMP1, ST_AMP2, ST_RAW, ST_FA, ST_FB, ST_FIN
   } state_type;

   typedef struct packed {
      logic [20:0] amp1;
      logic [31:0] dec1;
      logic [20:0] amp2;
      logic [31:0] dec2;
   } coef_type;

   typedef struct packed {
      logic [RATIO_W-1:0] filt;
      logic [RATIO_W-1:0] prev;
      logic               rise;
   } slot_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      slot_state_type    wr_data;
   } mem_req_type;

   typedef struct packed {
      logic           seen;
      slot_state_type st;
   } mem_rsp_type;

   // amplitudes in Q16, decay magnitudes in Q0.32
   function automatic coef_type coef_lookup(input logic [TYPE_W-1:0] stype,
                                            input logic [KIND_W-1:0] kind);
      coef_type c;
      c = '0;
      unique case ({stype, kind})
         4'h0: c = '{21'd394396,  32'd71382356,   21'd64435,  32'd2427086};
         4'h1: c = '{21'd1231421, 32'd45612553,   21'd402260, 32'd917405};
         4'h2: c = '{21'd254542,  32'd54546085,   21'd57311,  32'd1383838};
         4'h4: c = '{21'd30592,   32'd1395434874, 21'd21581,  32'd45140106};
         4'h5: c = '{21'd14431,   32'd481895331,  21'd54762,  32'd8297877};
         4'h8: c = '{21'd312345,  32'd7039451,    21'd229179, 32'd315594};
         4'h9: c = '{21'd215351,  32'd9496173,    21'd118358, 32'd442382};
         4'hA: c = '{21'd297206,  32'd7400229,    21'd176292, 32'd222952};
         default: c = '0;
      endcase
      return c;
   endfunction

   // exp(-2^(k-16)) in Q0.32
   function automatic logic [31:0] exp_factor(input logic [K_W-1:0] k);
      logic [31:0] f;
      f = '0;
      unique case (k)
         5'd0:  f = 32'd4294901760;
         5'd1:  f = 32'd4294836226;
         5'd2:  f = 32'd4294705160;
         5'd3:  f = 32'd4294443040;
         5'd4:  f = 32'd4293918848;
         5'd5:  f = 32'd4292870656;
         5'd6:  f = 32'd4290775039;
         5'd7:  f = 32'd4286586875;
         5'd8:  f = 32'd4278222805;
         5'd9:  f = 32'd4261543595;
         5'd10: f = 32'd4228380000;
         5'd11: f = 32'd4162825043;
         5'd12: f = 32'd4034748382;
         5'd13: f = 32'd3790295335;
         5'd14: f = 32'd3344923893;
         5'd15: f = 32'd2605029348;
         5'd16: f = 32'd1580030169;
         5'd17: f = 32'd581260615;
         5'd18: f = 32'd78665070;
         5'd19: f = 32'd1440801;
         default: f = '0;
      endcase
      return f;
   endfunction

   function automatic logic [RATIO_W-1:0] baseline(input logic [TYPE_W-1:0] stype);
      logic [RATIO_W-1:0] b;
      b = '0;
      unique case (stype)
         2'd0: b = 21'd1376256;
         2'd1: b = 21'd65536;
         2'd2: b = 21'd570163;
         default: b = '0;
      endcase
      return b;
   endfunction

   // slot number folded into the slot range
   function automatic logic [SLOT_W-1:0] slot_index(input logic [SLOTIN_W-1:0] s);
      logic [SLOTIN_W:0] v;
      v = {1'b0, s};
      for (int i = 0; i < 3; i++) begin
         if (int'(v) >= SENSOR_SLOTS) begin
            v = v - (SLOTIN_W+1)'(SENSOR_SLOTS);
         end
      end
      return SLOT_W'(v);
   endfunction

endpackage

// ===== hw/rtl/gas_sensor_response_model.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_response_model
// Metal-oxide gas sensor emulator with a per-slot asymmetric filter.
// ----------------------------------------------------------------------------
// Takes one item at a time and returns one filtered ratio per item. An item
// occupies the block from acceptance until its result is loaded into the
// output register, and the next item is taken only after that: one 33x32
// multiplier is shared by all products. Each exponential takes a scale
// step (ST_MAG), a round step (ST_ULD) and 20 factor steps (ST_EXP, one
// exp() factor each); the amplitude and filter products follow in ST_AMP1,
// ST_AMP2, ST_RAW, ST_FA, ST_FB and ST_FIN. req_stall is high while an item
// is in work; a finished result waits in the output register without
// holding up the next item. Slot state sits in a small synchronous memory
// read at acceptance and written back at the end, so no two accesses overlap.
// ----------------------------------------------------------------------------
module gas_sensor_response_model (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gsrm_pkg::CONC_W-1:0]   req_concentration,
   input  logic [gsrm_pkg::KIND_W-1:0]   req_gas_kind,
   input  logic [gsrm_pkg::SLOTIN_W-1:0] req_sensor_slot,
   input  logic [gsrm_pkg::TYPE_W-1:0]   req_sensor_type,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gsrm_pkg::RATIO_W-1:0]  rsp_filtered_ratio,
   input  logic                          csr_write_enable,
   input  logic [gsrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gsrm_pkg::CSR_W-1:0]    csr_write_data
);

   // control
   gsrm_pkg::state_type state_ff, state_in;
   logic accept, fin_fire;

   // item fields
   logic [gsrm_pkg::CONC_W-1:0] conc_ff, conc_in;
   logic [gsrm_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [gsrm_pkg::TYPE_W-1:0] type_ff, type_in;
   logic [gsrm_pkg::SLOT_W-1:0] slot_ff, slot_in;

   // exp sequencing
   logic                     sel_ff, sel_in;       // which exponential term
   logic [gsrm_pkg::K_W-1:0] k_ff, k_in;
   logic [19:0]              u_ff, u_in;
   logic                     u_big_ff, u_big_in;   // exponent >= 16: exp is 0
   logic [31:0]              r_ff, r_in;
   logic                     r_one_ff, r_one_in;   // r still exactly 1.0
   logic [32:0]              e0_ff, e0_in, e1_ff, e1_in;

   // shared multiplier and accumulators
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] prod;
   logic [64:0] p_ff, acc_ff, acc_in;

   // filter
   logic [gsrm_pkg::RATIO_W-1:0] raw_ff, raw_in;
   logic                         rise_ff, rise_in;
   logic [gsrm_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;

   // config
   logic [gsrm_pkg::ALPHA_W-1:0] alpha_rise_ff, alpha_rise_in;
   logic [gsrm_pkg::ALPHA_W-1:0] alpha_fall_ff, alpha_fall_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gsrm_pkg::RATIO_W-1:0] rsp_data_ff, rsp_data_in;

   gsrm_pkg::coef_type    coef;
   gsrm_pkg::mem_req_type mem_req;
   gsrm_pkg::mem_rsp_type mem_rsp;

   // working values
   logic [54:0] t_rnd;
   logic [64:0] step_rnd;
   logic [31:0] r_upd;
   logic        r_one_upd;
   logic [32:0] e_val;
   logic [65:0] raw_sum;
   logic [33:0] raw_full;
   logic [gsrm_pkg::RATIO_W-1:0] raw_val;
   logic        rise_val;
   logic [65:0] y_sum;
   logic [49:0] y_full;
   logic [gsrm_pkg::RATIO_W-1:0] y_val;

   gsrm_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign req_stall          = (state_ff != gsrm_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_ratio = rsp_data_ff;
   assign accept             = req_valid && !req_stall;

   assign coef = gsrm_pkg::coef_lookup(type_ff, kind_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         gsrm_pkg::ST_MAG: begin
            mul_a = 33'(conc_ff);
            mul_b = sel_ff ? coef.dec2 : coef.dec1;
         end
         gsrm_pkg::ST_EXP: begin
            mul_a = {1'b0, r_ff};
            mul_b = gsrm_pkg::exp_factor(k_ff);
         end
         gsrm_pkg::ST_AMP1: begin
            mul_a = e0_ff;
            mul_b = 32'(coef.amp1);
         end
         gsrm_pkg::ST_AMP2: begin
            mul_a = e1_ff;
            mul_b = 32'(coef.amp2);
         end
         gsrm_pkg::ST_FA: begin
            mul_a = 33'(raw_ff);
            mul_b = 32'(alpha_ff);
         end
         // kept through the final state so the product holds while it waits
         gsrm_pkg::ST_FB, gsrm_pkg::ST_FIN: begin
            mul_a = 33'(mem_rsp.st.filt);
            mul_b = 32'(17'h1_0000 - {1'b0, alpha_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = {32'b0, mul_a} * {33'b0, mul_b};

   // arithmetic around the multiplier
   always_comb begin
      // exponent magnitude, rounded to Q16
      t_rnd = p_ff[54:0] + 55'(1 << 23);

      // one factor step; r = 1.0 times a factor is the factor itself
      step_rnd  = prod + 65'(64'h8000_0000);
      r_upd     = r_ff;
      r_one_upd = r_one_ff;
      if (u_ff[k_ff]) begin
         r_one_upd = 1'b0;
         r_upd     = r_one_ff ? gsrm_pkg::exp_factor(k_ff) : step_rnd[63:32];
      end
      if (u_big_ff) begin
         e_val = '0;
      end else if (r_one_upd) begin
         e_val = 33'h1_0000_0000;
      end else begin
         e_val = {1'b0, r_upd};
      end

      // raw ratio
      raw_sum  = {1'b0, acc_ff} + {1'b0, p_ff} + 66'(64'h8000_0000);
      raw_full = raw_sum[65:32];
      if (conc_ff == '0) begin
         raw_val = gsrm_pkg::baseline(type_ff);
      end else if (raw_full > 34'(gsrm_pkg::RATIO_MAX)) begin
         raw_val = gsrm_pkg::RATIO_MAX;
      end else begin
         raw_val = raw_full[gsrm_pkg::RATIO_W-1:0];
      end
      if (raw_val > mem_rsp.st.prev) begin
         rise_val = 1'b1;
      end else if (raw_val < mem_rsp.st.prev) begin
         rise_val = 1'b0;
      end else begin
         rise_val = mem_rsp.st.rise;
      end

      // filter output and special cases
      y_sum  = {1'b0, acc_ff} + {1'b0, p_ff} + 66'(32768);
      y_full = y_sum[65:16];
      if (y_full > 50'(gsrm_pkg::RATIO_MAX)) begin
         y_val = gsrm_pkg::RATIO_MAX;
      end else begin
         y_val = y_full[gsrm_pkg::RATIO_W-1:0];
      end
      if (!mem_rsp.seen) begin
         y_val = gsrm_pkg::baseline(type_ff);
      end
      if (type_ff == gsrm_pkg::MODEL_ONE && kind_ff == gsrm_pkg::GAS_HYDROGEN) begin
         y_val = gsrm_pkg::HYDROGEN_FIXED;
      end
   end

   // sequencer: next state and datapath loads
   always_comb begin
      state_in      = state_ff;
      conc_in       = conc_ff;
      kind_in       = kind_ff;
      type_in       = type_ff;
      slot_in       = slot_ff;
      sel_in        = sel_ff;
      k_in          = k_ff;
      u_in          = u_ff;
      u_big_in      = u_big_ff;
      r_in          = r_ff;
      r_one_in      = r_one_ff;
      e0_in         = e0_ff;
      e1_in         = e1_ff;
      acc_in        = acc_ff;
      raw_in        = raw_ff;
      rise_in       = rise_ff;
      alpha_in      = alpha_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      alpha_rise_in = alpha_rise_ff;
      alpha_fall_in = alpha_fall_ff;
      fin_fire      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         unique case (gsrm_pkg::csr_index_type'(csr_index))
            gsrm_pkg::CSR_ALPHA_RISE: alpha_rise_in = csr_write_data;
            gsrm_pkg::CSR_ALPHA_FALL: alpha_fall_in = csr_write_data;
         endcase
      end

      unique case (state_ff)
         gsrm_pkg::ST_IDLE: begin
            if (accept) begin
               conc_in  = req_concentration;
               kind_in  = req_gas_kind;
               type_in  = req_sensor_type;
               slot_in  = gsrm_pkg::slot_index(req_sensor_slot);
               sel_in   = 1'b0;
               state_in = gsrm_pkg::ST_MAG;
            end
         end
         gsrm_pkg::ST_MAG: begin
            state_in = gsrm_pkg::ST_ULD;
         end
         gsrm_pkg::ST_ULD: begin
            u_in     = t_rnd[43:24];
            u_big_in = |t_rnd[54:44];
            k_in     = '0;
            r_in     = '0;
            r_one_in = 1'b1;
            state_in = gsrm_pkg::ST_EXP;
         end
         gsrm_pkg::ST_EXP: begin
            r_in     = r_upd;
            r_one_in = r_one_upd;
            k_in     = k_ff + 1'b1;
            if (k_ff == gsrm_pkg::K_W'(gsrm_pkg::EXP_STEPS - 1)) begin
               if (sel_ff) begin
                  e1_in    = e_val;
                  state_in = gsrm_pkg::ST_AMP1;
               end else begin
                  e0_in    = e_val;
                  sel_in   = 1'b1;
                  state_in = gsrm_pkg::ST_MAG;
               end
            end
         end
         gsrm_pkg::ST_AMP1: begin
            state_in = gsrm_pkg::ST_AMP2;
         end
         gsrm_pkg::ST_AMP2: begin
            acc_in   = p_ff;
            state_in = gsrm_pkg::ST_RAW;
         end
         gsrm_pkg::ST_RAW: begin
            raw_in   = raw_val;
            rise_in  = rise_val;
            alpha_in = rise_val ? alpha_rise_ff : alpha_fall_ff;
            state_in = gsrm_pkg::ST_FA;
         end
         gsrm_pkg::ST_FA: begin
            state_in = gsrm_pkg::ST_FB;
         end
         gsrm_pkg::ST_FB: begin
            acc_in   = p_ff;
            state_in = gsrm_pkg::ST_FIN;
         end
         gsrm_pkg::ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               fin_fire     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_val;
               state_in     = gsrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_req.rd_en   = accept;
      mem_req.rd_slot = gsrm_pkg::slot_index(req_sensor_slot);
      mem_req.wr_en   = fin_fire;
      mem_req.wr_slot = slot_ff;
      mem_req.wr_data = '{filt: y_val, prev: raw_ff, rise: rise_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gsrm_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         alpha_rise_ff <= 16'd9224;
         alpha_fall_ff <= 16'd50567;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         alpha_rise_ff <= alpha_rise_in;
         alpha_fall_ff <= alpha_fall_in;
      end
   end

   always_ff @(posedge clock) begin
      conc_ff     <= conc_in;
      kind_ff     <= kind_in;
      type_ff     <= type_in;
      slot_ff     <= slot_in;
      sel_ff      <= sel_in;
      k_ff        <= k_in;
      u_ff        <= u_in;
      u_big_ff    <= u_big_in;
      r_ff        <= r_in;
      r_one_ff    <= r_one_in;
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      p_ff        <= prod;
      acc_ff      <= acc_in;
      raw_ff      <= raw_in;
      rise_ff     <= rise_in;
      alpha_ff    <= alpha_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/gsrm_state_mem.sv =====
// ----------------------------------------------------------------------------
// gsrm_state_mem
// Per-slot filter state: synchronous memory plus seen flags.
// ----------------------------------------------------------------------------
module gsrm_state_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  gsrm_pkg::mem_req_type mem_req,
   output gsrm_pkg::mem_rsp_type mem_rsp
);

   gsrm_pkg::slot_state_type mem [gsrm_pkg::SENSOR_SLOTS];
   gsrm_pkg::slot_state_type rd_data_ff;
   logic [gsrm_pkg::SENSOR_SLOTS-1:0] seen_ff, seen_in;
   logic rd_seen_ff, rd_seen_in;

   always_comb begin
      seen_in    = seen_ff;
      rd_seen_in = rd_seen_ff;
      if (mem_req.wr_en) begin
         seen_in[mem_req.wr_slot] = 1'b1;
      end
      if (mem_req.rd_en) begin
         rd_seen_in = seen_ff[mem_req.rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         rd_seen_ff <= 1'b0;
      end else begin
         seen_ff    <= seen_in;
         rd_seen_ff <= rd_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_slot] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_slot];
      end
   end

   // unseen slot reads as its reset state
   always_comb begin
      mem_rsp.seen = rd_seen_ff;
      if (rd_seen_ff) begin
         mem_rsp.st = rd_data_ff;
      end else begin
         mem_rsp.st = '{filt: '0, prev: '0, rise: 1'b1};
      end
   end

endmodule

// ===== hw/rtl/gsrm_checker.sv =====
// ----------------------------------------------------------------------------
// gsrm_checker
// Port-level checks of the gas sensor response model, bound to the top.
// ----------------------------------------------------------------------------
`include "gas_sensor_response_model_macros.svh"

module gsrm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [gsrm_pkg::RATIO_W-1:0]   rsp_filtered_ratio
);

   // a held result keeps its value
   `GSRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_filtered_ratio))
   // one item at a time: busy right after an accept
   `GSRM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // no result can appear the cycle after an accept
   `GSRM_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

endmodule

bind gas_sensor_response_model gsrm_checker u_gsrm_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Gas sensor response model testbench
// Drives concentration items through the sensor emulator, predicts each
// filtered ratio with a fixed-point model of the exp sum and the per-slot
// asymmetric filter, and compares every result as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [gsrm_pkg::CONC_W-1:0]     req_concentration;
   logic [gsrm_pkg::KIND_W-1:0]     req_gas_kind;
   logic [gsrm_pkg::SLOTIN_W-1:0]   req_sensor_slot;
   logic [gsrm_pkg::TYPE_W-1:0]     req_sensor_type;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [gsrm_pkg::RATIO_W-1:0]    rsp_filtered_ratio;
   logic                            csr_write_enable;
   logic [gsrm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gsrm_pkg::CSR_W-1:0]      csr_write_data;

   gas_sensor_response_model DUT (.*);

   // predictor state, one entry per slot
   logic [15:0]  alpha_rise, alpha_fall;
   logic [20:0]  filt_q [gsrm_pkg::SENSOR_SLOTS];
   logic [20:0]  prev_raw [gsrm_pkg::SENSOR_SLOTS];
   bit           rising [gsrm_pkg::SENSOR_SLOTS];
   bit           seen [gsrm_pkg::SENSOR_SLOTS];

   logic [20:0]  ratio_queue [$];
   int           mismatches;
   int           results_seen;
   int           items_sent;

   // exp(-2^(k-16)) in Q0.32
   localparam logic [31:0] EXP_TAB [20] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
      32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
      32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825043,
      32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029348,
      32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801};

   function automatic logic [63:0] decay(input logic [63:0] mag, input logic [63:0] c);
      logic [63:0] u, r;
      u = (mag * c + 64'd8388608) >> 24;
      r = 64'h1_0000_0000;
      if (u >= 64'd1048576) return 64'd0;
      for (int k = 0; k < 20; k++)
         if (u[k]) r = (r * EXP_TAB[k] + 64'h8000_0000) >> 32;
      return r;
   endfunction

   function automatic logic [63:0] amp_tab(input int t, input int g, input int which);
      logic [63:0] a [3][3][4];
      a = '{'{'{394396, 71382356, 64435, 2427086},
              '{1231421, 45612553, 402260, 917405},
              '{254542, 54546085, 57311, 1383838}},
            '{'{30592, 1395434874, 21581, 45140106},
              '{14431, 481895331, 54762, 8297877},
              '{0, 0, 0, 0}},
            '{'{312345, 7039451, 229179, 315594},
              '{215351, 9496173, 118358, 442382},
              '{297206, 7400229, 176292, 222952}}};
      if (t > 2 || g > 2) return 64'd0;
      return a[t][g][which];
   endfunction

   function automatic logic [20:0] base_ratio(input int t);
      case (t)
         0: return 21'd1376256;
         1: return 21'd65536;
         2: return 21'd570163;
         default: return 21'd0;
      endcase
   endfunction

   // expected filtered ratio for one item; updates slot state
   function automatic logic [20:0] predict_ratio(input logic [21:0] conc, input int g,
                                                 input int s, input int t);
      logic [63:0] sum, raw, y, a;
      if (conc == 0) raw = 64'(base_ratio(t));
      else begin
         sum = amp_tab(t, g, 0) * decay(amp_tab(t, g, 1), 64'(conc))
             + amp_tab(t, g, 2) * decay(amp_tab(t, g, 3), 64'(conc));
         raw = (sum + 64'h8000_0000) >> 32;
         if (raw > 64'd2097151) raw = 64'd2097151;
      end
      if (raw > 64'(prev_raw[s])) rising[s] = 1;
      else if (raw < 64'(prev_raw[s])) rising[s] = 0;
      a = 64'(rising[s] ? alpha_rise : alpha_fall);
      y = (a * raw + (64'd65536 - a) * 64'(filt_q[s]) + 64'd32768) >> 16;
      if (y > 64'd2097151) y = 64'd2097151;
      if (!seen[s]) y = 64'(base_ratio(t));
      if (t == 1 && g == 2) y = 64'(gsrm_pkg::HYDROGEN_FIXED);
      seen[s] = 1;
      prev_raw[s] = raw[20:0];
      filt_q[s] = y[20:0];
      return y[20:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result checker
   logic [20:0] want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (ratio_queue.size() == 0) report_mismatch("result with nothing expected");
         else begin
            want = ratio_queue.pop_front();
            if (rsp_filtered_ratio !== want)
               report_mismatch($sformatf("filtered_ratio got %0d want %0d",
                                         rsp_filtered_ratio, want));
         end
      end
   end

   // receiver stall: random hold per item, with quiet stretches
   bit rx_calm;
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (rx_calm) rsp_stall <= 0;
         else begin
            n = $urandom_range(0, 18);
            if (n != 0) begin
               rsp_stall <= 1;
               repeat (n) @(negedge clock);
            end
            rsp_stall <= 0;
         end
      end
   end

   // valid stays high into a back-to-back item; it drops only before a gap
   bit tx_calm;
   task automatic send_item(input logic [21:0] conc, input int g, input int s, input int t);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      ratio_queue.push_back(predict_ratio(conc, g, s % gsrm_pkg::SENSOR_SLOTS, t));
      req_valid         <= 1;
      req_concentration <= conc;
      req_gas_kind      <= gsrm_pkg::KIND_W'(g);
      req_sensor_slot   <= gsrm_pkg::SLOTIN_W'(s);
      req_sensor_type   <= gsrm_pkg::TYPE_W'(t);
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // registers change only with the pipeline drained
   task automatic write_alphas(input logic [15:0] rise, input logic [15:0] fall);
      req_valid <= 0;
      while (ratio_queue.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_write_enable <= 1;
      csr_index        <= gsrm_pkg::CSR_ALPHA_RISE;
      csr_write_data   <= rise;
      @(negedge clock);
      csr_index        <= gsrm_pkg::CSR_ALPHA_FALL;
      csr_write_data   <= fall;
      @(negedge clock);
      csr_write_enable <= 0;
      alpha_rise = rise;
      alpha_fall = fall;
   endtask

   task automatic random_conc(output logic [21:0] c);
      case ($urandom_range(0, 5))
         0: c = 0;
         1: c = 22'($urandom_range(1, 255));
         2: c = 22'($urandom_range(1, 65535));
         3: c = 22'($urandom_range(1, 1 << 18));
         default: c = 22'($urandom);
      endcase
   endtask

   // extremes, every gas/model pair, zero concentration, first items per slot
   task automatic test_directed();
      send_item(0, 0, 0, 0);
      send_item(22'h3FFFFF, 0, 0, 0);
      send_item(1, 1, 1, 2);
      send_item(22'h3FFFFF, 3, 1, 2);
      send_item(0, 2, 2, 1);
      send_item(256, 2, 2, 1);
      send_item(0, 3, 3, 3);
      send_item(100, 0, 3, 3);
      for (int t = 0; t < 4; t++)
         for (int g = 0; g < 4; g++)
            if (items_sent < 25) send_item(22'(22'h2AAAAA ^ (g << 7)), g, t, t);
   endtask

   task automatic test_random(input int count);
      logic [21:0] c;
      for (int i = 0; i < count; i++) begin
         random_conc(c);
         send_item(c, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
      end
   endtask

   task automatic test_alpha_settings();
      write_alphas(16'd0, 16'hFFFF);
      test_random(80);
      write_alphas(16'hFFFF, 16'd0);
      test_random(80);
      write_alphas(16'($urandom), 16'($urandom));
      tx_calm = 1; rx_calm = 1;
      test_random(80);
      tx_calm = 0; rx_calm = 0;
      write_alphas(16'h5555, 16'hAAAA);
      test_random(80);
   endtask

   initial begin
      int guard;
      reset = 1;
      req_valid = 0; req_concentration = 0; req_gas_kind = 0;
      req_sensor_slot = 0; req_sensor_type = 0;
      csr_write_enable = 0; csr_index = gsrm_pkg::CSR_ALPHA_RISE; csr_write_data = 0;
      mismatches = 0; results_seen = 0; items_sent = 0;
      alpha_rise = 16'd9224; alpha_fall = 16'd50567;
      for (int i = 0; i < gsrm_pkg::SENSOR_SLOTS; i++) begin
         filt_q[i] = 0; prev_raw[i] = 0; rising[i] = 1; seen[i] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_directed();
      test_random(160);
      test_alpha_settings();

      req_valid <= 0;
      guard = 0;
      while (ratio_queue.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (60) @(negedge clock);
      if (ratio_queue.size() != 0) report_mismatch("expected results never arrived");

      $display("covered %0d items, %0d results, five alpha settings", items_sent,
               results_seen);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
